### rtl/bemf_pkg.sv
// ---------------------------------------------------------------------------
// bemf_pkg
// shared types, constants and the quarter-wave sine entry function
// ---------------------------------------------------------------------------
`default_nettype none
package bemf_pkg;

  localparam int NUM_COEFF_REGS = 5;
  localparam int CFG_INDEX_W    = 3;
  localparam int COEFF_W        = 16;
  localparam int ANGLE_W        = 16;
  localparam int VEL_W          = 32;
  localparam int NORM_W         = 20;
  localparam int EMF_W          = 48;
  localparam int SINE_W         = 15;   // table magnitude, 0..32767
  localparam int STAGES         = 6;

  localparam logic [ANGLE_W-1:0] THIRD_TURN      = 16'd21845;
  localparam logic [ANGLE_W-1:0] TWO_THIRDS_TURN = 16'd43691;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_HARM1 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HARM3 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HARM5 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HARM7 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HARM9 = 3'd4;

  typedef logic [NUM_COEFF_REGS-1:0][COEFF_W-1:0] coeff_bank_t;

  // per-stage advance strobes, stage 0 is the address stage
  typedef struct packed {
    logic [STAGES-1:0] en;
  } stage_ctrl_t;

  // taylor series sine, q30 with truncating steps, scaled to 32767
  function automatic logic [SINE_W-1:0] sine_entry(input int idx, input int bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    x    = (64'd1686629713 * 64'(idx)) >> bits;
    x2   = (x * x) >> 30;
    term = ((x * x2) >> 30) / 64'd6;
    sum  = longint'(x) - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
    if (v > 32767) v = 32767;
    return SINE_W'(v);
  endfunction

endpackage
`default_nettype wire

### rtl/bemf_sine_rom.sv
// ---------------------------------------------------------------------------
// bemf_sine_rom
// quarter-wave sine rom with registered read
// ---------------------------------------------------------------------------
`default_nettype none
module bemf_sine_rom
  import bemf_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [SINE_TABLE_BITS:0]   addr,
  output logic      [SINE_W-1:0]          data
);
  localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

  logic [SINE_W-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [SINE_W-1:0] VAL = sine_entry(i, SINE_TABLE_BITS);
    assign rom[i] = VAL;
  end

  always_ff @(posedge clk) begin
    if (en) data <= rom[addr];
  end
endmodule
`default_nettype wire

### rtl/bemf_phase_lane.sv
// ---------------------------------------------------------------------------
// bemf_phase_lane
// one phase: harmonic addressing, rom, products, sum, velocity scaling
// ---------------------------------------------------------------------------
`default_nettype none
module bemf_phase_lane
  import bemf_pkg::*;
#(
  parameter int NUM_HARMONICS   = 5,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                      clk,
  input  wire stage_ctrl_t               ctrl,
  input  wire logic [ANGLE_W-1:0]        phase,
  input  wire coeff_bank_t               coeff,
  input  wire logic signed [VEL_W-1:0]   vel_d,
  output logic signed [NORM_W-1:0]       norm,
  output logic signed [EMF_W-1:0]        emf
);
  localparam int B      = SINE_TABLE_BITS;
  localparam int PROD_W = COEFF_W + SINE_W + 2;
  localparam int ACC_W  = PROD_W + 1 + $clog2(NUM_HARMONICS);
  localparam int MUL_W  = NORM_W + VEL_W;
  localparam logic [B:0] QUARTER = (B+1)'(1 << B);
  localparam logic signed [ACC_W-1:0] NORM_HI = ACC_W'(524287);
  localparam logic signed [ACC_W-1:0] NORM_LO = ACC_W'(-524288);

  logic [NUM_HARMONICS-1:0][B:0]        addr_a;
  logic [NUM_HARMONICS-1:0]             neg_a;
  logic [NUM_HARMONICS-1:0][SINE_W-1:0] mag_b;
  logic [NUM_HARMONICS-1:0]             neg_b;
  logic signed [PROD_W-1:0]             prod_c [NUM_HARMONICS];
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W-1:0]              rnd;
  logic signed [NORM_W-1:0]             norm_d;
  logic signed [MUL_W-1:0]              mul_e;
  logic signed [MUL_W-1:0]              mul_rnd;

  for (genvar k = 0; k < NUM_HARMONICS; k++) begin : g_harm
    logic [ANGLE_W-1:0]      p;
    logic [B-1:0]            w;
    logic signed [COEFF_W:0] c;
    logic signed [SINE_W+1:0] s;

    assign p = ANGLE_W'(phase * ANGLE_W'(2*k + 1));
    assign w = p[13 -: B];

    // stage a: table address and sign of the quadrant
    always_ff @(posedge clk) begin
      if (ctrl.en[0]) begin
        addr_a[k] <= p[14] ? (QUARTER - (B+1)'(w)) : (B+1)'(w);
        neg_a[k]  <= p[15];
      end
    end

    // stage b: rom data
    bemf_sine_rom #(.SINE_TABLE_BITS(B)) u_rom (
      .clk  (clk),
      .en   (ctrl.en[1]),
      .addr (addr_a[k]),
      .data (mag_b[k])
    );

    always_ff @(posedge clk) begin
      if (ctrl.en[1]) neg_b[k] <= neg_a[k];
    end

    // harmonics beyond the register bank weigh nothing
    if (k < NUM_COEFF_REGS) begin : g_c
      assign c = (COEFF_W+1)'($signed(coeff[k]));
    end else begin : g_z
      assign c = '0;
    end

    assign s = neg_b[k] ? -$signed({2'b00, mag_b[k]}) : $signed({2'b00, mag_b[k]});

    // stage c: product
    always_ff @(posedge clk) begin
      if (ctrl.en[2]) prod_c[k] <= PROD_W'(c * s);
    end
  end

  always_comb begin
    acc = '0;
    for (int k = 0; k < NUM_HARMONICS; k++) acc = acc + ACC_W'(prod_c[k]);
    rnd = (acc + ACC_W'(1 << 14)) >>> 15;
  end

  // stage d: rounded, saturated sum
  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      if (rnd > NORM_HI)      norm_d <= NORM_W'(NORM_HI);
      else if (rnd < NORM_LO) norm_d <= NORM_W'(NORM_LO);
      else                    norm_d <= NORM_W'(rnd);
    end
  end

  // stage e: velocity product
  always_ff @(posedge clk) begin
    if (ctrl.en[4]) mul_e <= MUL_W'(norm_d * vel_d);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) norm <= norm_d;
  end

  // stage f: round; the result always fits 48 bits
  assign mul_rnd = mul_e + MUL_W'(1 << 14);

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) emf <= EMF_W'($signed(mul_rnd[MUL_W-1:15]));
  end
endmodule
`default_nettype wire

### rtl/three_phase_back_emf_harmonics_core.sv
// ---------------------------------------------------------------------------
// three_phase_back_emf_harmonics_core
// three-phase back-emf from an odd-harmonic sine series, streaming pipeline
// ---------------------------------------------------------------------------
// channel  | direction | payload (lowest bit first)
// s_axis   | in        | angle_turns[15:0], elec_velocity[31:0]
// m_axis   | out       | norm a/b/c 20b each, emf a/b/c 48b each, 4b zero pad
// cfg      | in        | cfg_index selects coeff_harm1..9, cfg_data 16b
//
// one beat per cycle sustained unless m_axis_tready stalls the pipe; each beat runs
// through the address, rom read, products, sum, velocity product and round stages
// each stage holds while its successor is full and stalled, so bubbles close up
// rst clears valid bits and the coefficients to their reset values
// ---------------------------------------------------------------------------
`default_nettype none
module three_phase_back_emf_harmonics_core
  import bemf_pkg::*;
#(
  parameter int NUM_HARMONICS   = 5,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // angle_turns[15:0], elec_velocity[47:16]
  input  wire logic [47:0]            s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // norm_phase_a[19:0], norm_phase_b[39:20], norm_phase_c[59:40],
  // emf_phase_a[107:60], emf_phase_b[155:108], emf_phase_c[203:156], zero pad
  output logic [207:0]                m_axis_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [COEFF_W-1:0]     cfg_data
);
  coeff_bank_t           coeff;
  stage_ctrl_t           ctrl;
  logic [STAGES-1:0]     vld;
  logic [ANGLE_W-1:0]    angle;
  logic signed [VEL_W-1:0] vel_in;
  logic signed [VEL_W-1:0] vel_a, vel_b, vel_c, vel_d;
  logic [2:0][ANGLE_W-1:0] phase;
  logic signed [NORM_W-1:0] norm [3];
  logic signed [EMF_W-1:0]  emf  [3];

  // coefficient registers, writes always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      // fundamental at full scale, the other harmonics cleared
      coeff <= {{((NUM_COEFF_REGS-1)*COEFF_W){1'b0}}, 16'h7fff};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HARM1: coeff[0] <= cfg_data;
        REG_HARM3: coeff[1] <= cfg_data;
        REG_HARM5: coeff[2] <= cfg_data;
        REG_HARM7: coeff[3] <= cfg_data;
        REG_HARM9: coeff[4] <= cfg_data;
        default: ;   // index beyond the bank is ignored
      endcase
    end
  end

  // stall chain: a stage moves when empty or when the next one moves
  always_comb begin
    ctrl.en[STAGES-1] = !vld[STAGES-1] || m_axis_tready;
    for (int i = STAGES-2; i >= 0; i--) ctrl.en[i] = !vld[i] || ctrl.en[i+1];
  end

  assign s_axis_tready = ctrl.en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctrl.en[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < STAGES; i++) begin
        if (ctrl.en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // velocity follows the items to the product stage
  assign angle  = s_axis_tdata[15:0];
  assign vel_in = $signed(s_axis_tdata[47:16]);

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) vel_a <= vel_in;
    if (ctrl.en[1]) vel_b <= vel_a;
    if (ctrl.en[2]) vel_c <= vel_b;
    if (ctrl.en[3]) vel_d <= vel_c;
  end

  // phases a, b, c: angle, minus one third, minus two thirds of a turn
  assign phase[0] = angle;
  assign phase[1] = angle - THIRD_TURN;
  assign phase[2] = angle - TWO_THIRDS_TURN;

  for (genvar j = 0; j < 3; j++) begin : g_lane
    bemf_phase_lane #(
      .NUM_HARMONICS   (NUM_HARMONICS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_lane (
      .clk   (clk),
      .ctrl  (ctrl),
      .phase (phase[j]),
      .coeff (coeff),
      .vel_d (vel_d),
      .norm  (norm[j]),
      .emf   (emf[j])
    );
  end

  // norm leaves the lane one stage early, hold it beside emf
  logic signed [NORM_W-1:0] norm_f [3];

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      for (int j = 0; j < 3; j++) norm_f[j] <= norm[j];
    end
  end

  assign m_axis_tvalid = vld[STAGES-1];
  assign m_axis_tdata  = {4'b0000, emf[2], emf[1], emf[0],
                          norm_f[2], norm_f[1], norm_f[0]};
endmodule
`default_nettype wire
